### hdl/cpg_pkg.sv
// shared types and constants of the cell pattern generator
package cpg_pkg;

  // pattern mode codes
  typedef enum logic [2:0] {
    MODE_CHECKER  = 3'd0,
    MODE_STRIPES  = 3'd1,
    MODE_SCANLINE = 3'd2,
    MODE_GRID     = 3'd3,
    MODE_HATCH    = 3'd4,
    MODE_DOTS     = 3'd5,
    MODE_NOISE    = 3'd6
  } mode_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_MODE    = 3'd0,
    REG_PERIOD  = 3'd1,
    REG_COLOR_A = 3'd2,
    REG_COLOR_B = 3'd3,
    REG_WEIGHT_A = 3'd4,
    REG_WEIGHT_B = 3'd5,
    REG_STOPS   = 3'd6
  } cfg_idx_t;

  // static settings seen by the noise path
  typedef struct packed {
    logic [7:0] alpha_a;
    logic [7:0] period;
  } nz_cfg_t;

  // pipeline depth of the noise path
  localparam int NZ_LAT = 10;
  // numerator width of the duty division
  localparam int DUTY_BITS = 17;

endpackage

### hdl/cpg_div.sv
// pipelined restoring divider, one quotient bit per stage
module cpg_div #(
  parameter int NUM_BITS = 17,
  parameter int DEN_BITS = 8,
  parameter int TAG_BITS = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic [NUM_BITS-1:0] num_i,
  input  logic [DEN_BITS-1:0] den_i,
  input  logic [TAG_BITS-1:0] tag_i,
  output logic [NUM_BITS-1:0] quo_o,
  output logic [DEN_BITS-1:0] rem_o,
  output logic [TAG_BITS-1:0] tag_o
);

  logic [DEN_BITS-1:0] rem_r [NUM_BITS];
  logic [NUM_BITS-1:0] nq_r  [NUM_BITS];
  logic [DEN_BITS-1:0] den_r [NUM_BITS];
  logic [TAG_BITS-1:0] tag_r [NUM_BITS];

  for (genvar s = 0; s < NUM_BITS; s++) begin : stage_g
    logic [DEN_BITS-1:0] rem_p;
    logic [NUM_BITS-1:0] nq_p;
    logic [DEN_BITS-1:0] den_p;
    logic [TAG_BITS-1:0] tag_p;
    logic [DEN_BITS:0]   trial;
    logic [DEN_BITS:0]   diff;
    logic                ge;

    // previous stage or the input beat
    if (s == 0) begin : first_g
      assign rem_p = '0;
      assign nq_p  = num_i;
      assign den_p = den_i;
      assign tag_p = tag_i;
    end else begin : next_g
      assign rem_p = rem_r[s-1];
      assign nq_p  = nq_r[s-1];
      assign den_p = den_r[s-1];
      assign tag_p = tag_r[s-1];
    end

    // trial subtract of one numerator bit
    assign trial = {rem_p, nq_p[NUM_BITS-1]};
    assign diff  = trial - {1'b0, den_p};
    assign ge    = (trial >= {1'b0, den_p});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= ge ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
        nq_r[s]  <= {nq_p[NUM_BITS-2:0], ge};
        den_r[s] <= den_p;
      end
    end

    // tag carries valid bits, so it is cleared on reset
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tag_r[s] <= '0;
      end else if (en) begin
        tag_r[s] <= tag_p;
      end
    end
  end

  assign quo_o = nq_r[NUM_BITS-1];
  assign rem_o = rem_r[NUM_BITS-1];
  assign tag_o = tag_r[NUM_BITS-1];

endmodule

### hdl/cpg_noise.sv
// coordinate hash and jittered alpha of the noise pattern
module cpg_noise (
  input  logic             clk,
  input  logic             en,
  input  logic [31:0]      x_i,
  input  logic [31:0]      y_i,
  input  cpg_pkg::nz_cfg_t cfg_i,
  output logic [7:0]       alpha_o
);

  localparam logic [31:0] HASH_X   = 32'h9E3779B9;
  localparam logic [31:0] HASH_Y   = 32'h85EBCA6B;
  localparam logic [31:0] HASH_MIX = 32'hC2B2AE35;
  localparam logic [25:0] RECIP    = 26'd43980466;  // ceil(2^42 / 100000)

  logic [31:0] h1_r, h2_r;
  logic [26:0] v1_r;
  logic [21:0] v2_r;
  logic [11:0] v4_r;
  logic signed [20:0] prod_r;
  logic signed [27:0] n_r;
  logic [24:0] v_r;
  logic        neg_r, sat_r, neg2_r, sat2_r;
  logic [50:0] p2_r;
  logic [7:0]  alpha_r;

  logic [31:0] h1_nxt, t2, h2_nxt, t3;
  logic [26:0] v1_nxt;
  logic [21:0] v2_nxt;
  logic [16:0] v3;
  logic [11:0] v4_nxt;
  logic [10:0] k;
  logic signed [11:0] d;
  logic signed [20:0] prod_nxt;
  logic signed [27:0] base, n_nxt, rsum;

  // first hash multiplies
  assign h1_nxt = (x_i * HASH_X) ^ (y_i * HASH_Y);
  // avalanche multiply
  assign t2     = h1_r ^ (h1_r >> 15);
  assign h2_nxt = t2 * HASH_MIX;
  // fold of 2^16 modulo 2001
  assign t3     = h2_r ^ (h2_r >> 13);
  assign v1_nxt = 27'(t3[31:16]) * 27'd1504 + 27'(t3[15:0]);
  // folds of 2^11 modulo 2001
  assign v2_nxt = 22'(v1_r[26:11]) * 22'd47 + 22'(v1_r[10:0]);
  assign v3     = 17'(v2_r[21:11]) * 17'd47 + 17'(v2_r[10:0]);
  assign v4_nxt = 12'(v3[16:11]) * 12'd47 + 12'(v3[10:0]);
  // final reduction and offset times amplitude
  assign k        = (v4_r >= 12'd2001) ? 11'(v4_r - 12'd2001) : v4_r[10:0];
  assign d        = signed'({1'b0, k}) - 12'sd1000;
  assign prod_nxt = 21'(d) * 21'(signed'({1'b0, cfg_i.period}));
  // numerator of the rounded alpha
  assign base  = signed'(28'(cfg_i.alpha_a) * 28'd100000);
  assign n_nxt = base + 28'(prod_r) * 28'sd255;
  assign rsum  = n_r + 28'sd50000;

  always_ff @(posedge clk) begin
    if (en) begin
      h1_r    <= h1_nxt;
      h2_r    <= h2_nxt;
      v1_r    <= v1_nxt;
      v2_r    <= v2_nxt;
      v4_r    <= v4_nxt;
      prod_r  <= prod_nxt;
      n_r     <= n_nxt;
      neg_r   <= n_r[27];
      sat_r   <= !n_r[27] && (rsum >= 28'sd25600000);
      v_r     <= rsum[24:0];
      p2_r    <= 51'(v_r) * 51'(RECIP);
      neg2_r  <= neg_r;
      sat2_r  <= sat_r;
      alpha_r <= neg2_r ? 8'd0 : (sat2_r ? 8'd255 : p2_r[49:42]);
    end
  end

  assign alpha_o = alpha_r;

endmodule

### hdl/cell_pattern_generator.sv
// top level of the cell pattern generator
// each beat is registered through the divider stages and then the output register
// throughput: one beat per cycle; depth set by the restoring dividers, one bit a stage
// a stalled result holds the whole pipeline in place
// reset: registers return to mode checker, period 1, colors 0, weights 1, no stops
// reset also empties every valid bit of the pipeline
module cell_pattern_generator #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] in_cell_x,
  input  logic signed [COORD_BITS-1:0] in_cell_y,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [7:0]                   out_red,
  output logic [7:0]                   out_green,
  output logic [7:0]                   out_blue,
  output logic [7:0]                   out_alpha,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [2:0]                   cfg_index,
  input  logic [31:0]                  cfg_data
);

  localparam int VW   = COORD_BITS + 1;
  localparam int DEPTH = (VW > cpg_pkg::DUTY_BITS) ? VW : cpg_pkg::DUTY_BITS;
  localparam int PAD  = DEPTH - cpg_pkg::NZ_LAT;

  cpg_pkg::mode_t mode_r;
  logic [7:0]  period_r, weight_a_r, weight_b_r;
  logic [31:0] color_a_r, color_b_r;
  logic [1:0]  stop_count_r;

  // configuration writes
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= cpg_pkg::MODE_CHECKER;
      period_r     <= 8'd1;
      color_a_r    <= '0;
      color_b_r    <= '0;
      weight_a_r   <= 8'd1;
      weight_b_r   <= 8'd1;
      stop_count_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cpg_pkg::REG_MODE:     mode_r       <= cpg_pkg::mode_t'(cfg_data[2:0]);
        cpg_pkg::REG_PERIOD:   period_r     <= cfg_data[7:0];
        cpg_pkg::REG_COLOR_A:  color_a_r    <= cfg_data;
        cpg_pkg::REG_COLOR_B:  color_b_r    <= cfg_data;
        cpg_pkg::REG_WEIGHT_A: weight_a_r   <= cfg_data[7:0];
        cpg_pkg::REG_WEIGHT_B: weight_b_r   <= cfg_data[7:0];
        cpg_pkg::REG_STOPS:    stop_count_r <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // derived settings
  logic [7:0] p_eff, wa, wb;
  logic [1:0] stops;
  logic [8:0] wsum;
  logic [15:0] pb;
  logic [cpg_pkg::DUTY_BITS-1:0] duty_num;
  logic [9:0] duty_den;
  assign p_eff    = (period_r == 8'd0) ? 8'd1 : period_r;
  assign wa       = (weight_a_r == 8'd0) ? 8'd1 : weight_a_r;
  assign wb       = (weight_b_r == 8'd0) ? 8'd1 : weight_b_r;
  assign stops    = (stop_count_r == 2'd3) ? 2'd2 : stop_count_r;
  assign wsum     = {1'b0, wa} + {1'b0, wb};
  assign pb       = 16'(p_eff) * 16'(wb);
  assign duty_num = {pb, 1'b0} + cpg_pkg::DUTY_BITS'(wsum);
  assign duty_den = {wsum, 1'b0};

  // pipeline advance
  logic en, out_valid_r;
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // divider operands: magnitude of floor form
  logic signed [VW-1:0] x_ext, y_ext, opa;
  logic [COORD_BITS-1:0] mag_a, mag_b;
  assign x_ext = VW'(in_cell_x);
  assign y_ext = VW'(in_cell_y);
  always_comb begin
    case (mode_r)
      cpg_pkg::MODE_STRIPES:  opa = x_ext + y_ext;
      cpg_pkg::MODE_SCANLINE: opa = y_ext;
      cpg_pkg::MODE_HATCH:    opa = x_ext - y_ext;
      default:                opa = x_ext;
    endcase
  end
  assign mag_a = opa[VW-1]   ? ~opa[COORD_BITS-1:0]   : opa[COORD_BITS-1:0];
  assign mag_b = y_ext[VW-1] ? ~y_ext[COORD_BITS-1:0] : y_ext[COORD_BITS-1:0];

  logic [DEPTH-1:0] quo_a, quo_b, quo_d;
  logic [7:0] rem_a, rem_b;
  logic [9:0] rem_d;
  logic       neg_a, vld_d;
  logic [1:0] tag_b;

  cpg_div #(.NUM_BITS(DEPTH), .DEN_BITS(8), .TAG_BITS(1)) u_div_a (
    .clk(clk), .rst_n(rst_n), .en(en),
    .num_i(DEPTH'(mag_a)), .den_i(p_eff), .tag_i(opa[VW-1]),
    .quo_o(quo_a), .rem_o(rem_a), .tag_o(neg_a)
  );

  cpg_div #(.NUM_BITS(DEPTH), .DEN_BITS(8), .TAG_BITS(2)) u_div_b (
    .clk(clk), .rst_n(rst_n), .en(en),
    .num_i(DEPTH'(mag_b)), .den_i(p_eff), .tag_i({y_ext[VW-1], y_ext[0]}),
    .quo_o(quo_b), .rem_o(rem_b), .tag_o(tag_b)
  );

  // duty division, carries the valid bit
  cpg_div #(.NUM_BITS(DEPTH), .DEN_BITS(10), .TAG_BITS(1)) u_div_d (
    .clk(clk), .rst_n(rst_n), .en(en),
    .num_i(DEPTH'(duty_num)), .den_i(duty_den), .tag_i(in_valid),
    .quo_o(quo_d), .rem_o(rem_d), .tag_o(vld_d)
  );

  // noise path and its alignment line
  cpg_pkg::nz_cfg_t nz_cfg;
  logic [7:0] nz_alpha;
  logic [7:0] nz_pipe_r [PAD];
  assign nz_cfg.alpha_a = color_a_r[7:0];
  assign nz_cfg.period  = p_eff;

  cpg_noise u_noise (
    .clk(clk), .en(en),
    .x_i(32'(in_cell_x)), .y_i(32'(in_cell_y)),
    .cfg_i(nz_cfg), .alpha_o(nz_alpha)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      nz_pipe_r[0] <= nz_alpha;
      for (int i = 1; i < PAD; i++) nz_pipe_r[i] <= nz_pipe_r[i-1];
    end
  end

  // phase decision
  logic [7:0] pos_a, pos_b, duty;
  logic       fl_a, fl_b, phase;
  logic [31:0] color_nxt;
  assign pos_a = neg_a    ? (p_eff - 8'd1 - rem_a) : rem_a;
  assign pos_b = tag_b[1] ? (p_eff - 8'd1 - rem_b) : rem_b;
  assign fl_a  = quo_a[0] ^ neg_a;
  assign fl_b  = quo_b[0] ^ tag_b[1];

  always_comb begin
    if (stops < 2'd2 || p_eff <= 8'd1) begin
      duty = p_eff >> 1;
    end else if (quo_d[7:0] == 8'd0) begin
      duty = 8'd1;
    end else if (quo_d[7:0] > p_eff - 8'd1) begin
      duty = p_eff - 8'd1;
    end else begin
      duty = quo_d[7:0];
    end
  end

  always_comb begin
    case (mode_r)
      cpg_pkg::MODE_CHECKER:  phase = fl_a ^ fl_b;
      cpg_pkg::MODE_STRIPES:  phase = pos_a < duty;
      cpg_pkg::MODE_SCANLINE: phase = (p_eff == 8'd1) ? !tag_b[0] : (pos_b < duty);
      cpg_pkg::MODE_GRID:     phase = (pos_a == 8'd0) || (pos_b == 8'd0);
      cpg_pkg::MODE_HATCH:    phase = pos_a == 8'd0;
      cpg_pkg::MODE_DOTS:     phase = (pos_a == 8'd0) && (pos_b == 8'd0);
      default:                phase = 1'b0;
    endcase
  end

  // color select
  always_comb begin
    if (stops == 2'd0) begin
      color_nxt = '0;
    end else if (mode_r == cpg_pkg::MODE_NOISE) begin
      color_nxt = {color_a_r[31:8], nz_pipe_r[PAD-1]};
    end else if (!phase) begin
      color_nxt = color_a_r;
    end else begin
      color_nxt = (stops > 2'd1) ? color_b_r : 32'd0;
    end
  end

  // output register
  logic [31:0] color_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_d;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      color_r <= color_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_red   = color_r[31:24];
  assign out_green = color_r[23:16];
  assign out_blue  = color_r[15:8];
  assign out_alpha = color_r[7:0];

  // checks
  a_stall_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow the output register");

  a_reset_empties: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  a_no_stops_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && stop_count_r == 2'd0) |->
    (out_red == 8'd0 && out_green == 8'd0 && out_blue == 8'd0 && out_alpha == 8'd0))
    else $error("color given with no stops");

  a_noise_keeps_rgb: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && mode_r == cpg_pkg::MODE_NOISE && stop_count_r != 2'd0) |->
    (out_red == color_a_r[31:24] && out_blue == color_a_r[15:8]))
    else $error("noise changed the first color");

endmodule
